FILE: hdl/hlcw_pkg.sv
// hlcw_pkg: shared sizes for the hex line cell walker.
// No dependencies.
package hlcw_pkg;
  localparam int unsigned MaxCoordBits = 5;
endpackage

FILE: hdl/hlcw_if.sv
// hlcw_in_if / hlcw_out_if: valid/ready channels of the hex line walker.
// Depends on nothing.
interface hlcw_in_if #(parameter int unsigned W = 5);
  logic valid;
  logic ready;
  logic signed [W-1:0] start_q;
  logic signed [W-1:0] start_r;
  logic signed [W-1:0] end_q;
  logic signed [W-1:0] end_r;
  modport source(output valid, start_q, start_r, end_q, end_r, input ready);
  modport sink(input valid, start_q, start_r, end_q, end_r, output ready);
endinterface

interface hlcw_out_if #(parameter int unsigned W = 5);
  logic valid;
  logic ready;
  logic signed [W-1:0] cell_q;
  logic signed [W-1:0] cell_r;
  logic is_last;
  modport source(output valid, cell_q, cell_r, is_last, input ready);
  modport sink(input valid, cell_q, cell_r, is_last, output ready);
endinterface

FILE: hdl/hex_line_cell_walker.sv
// hex_line_cell_walker: streams the cells of a hex grid line.
// Depends on hlcw_if.sv for the channel interfaces.
//
// One input transfer (start, end in axial coordinates) yields d+1 output
// transfers, d the hex distance, the last flagged with is_last. The block takes
// one line at a time: a step counter issues one step per cycle while the output
// is not stalled, and the input is ready again once the last step has issued
// (d=62 for the longest line). Each step runs through a six-stage pipeline:
// (1) numerators over d, (2) magnitude and rounding offset, (3)-(5) restoring
// division by 2d, two quotient bits per stage, (6) error compare, fix-up and
// output register. A cell reaches the output from the stage 6 register once its
// step has passed stages 1 to 5 in order. The rounding error of each cube
// component falls out of the division remainder, so no multiply is needed for
// it. Valid bits travel with every stage and the whole pipe, step counter
// included, holds while the output is not taken.
module hex_line_cell_walker #(
  parameter int unsigned COORD_BITS = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  hlcw_in_if.sink    in_i,
  hlcw_out_if.source out_o
);
  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned DW = W + 2;          // distance, up to 2^(W+1)-2
  localparam int unsigned NW = 2*W + 4;        // numerator width, signed
  localparam int unsigned QW = W + 2;          // rounded value width, signed
  localparam int unsigned QB = W + 1;          // quotient bits, |component| <= 2^W
  localparam int B1_LO = int'((2 * QB) / 3);   // lowest quotient bit of division stage 1
  localparam int B2_LO = int'(QB / 3);         // lowest quotient bit of division stage 2

  typedef logic signed [NW-1:0] num_t;
  typedef logic [NW-1:0] mag_t;
  typedef logic [QB-1:0] quo_t;
  typedef struct packed {
    mag_t a;    // running remainder
    quo_t k;    // quotient bits found so far
  } div_t;

  // line registers
  logic              busy_q, busy_d;
  logic signed [W:0] q0_q, r0_q, dq_q, dr_q;
  logic [DW-1:0]     d_q, i_q;

  logic stall;
  assign stall = out_o.valid && !out_o.ready;
  assign in_i.ready = !busy_q;

  // distance of the incoming line
  logic signed [W:0] dq_w, dr_w;
  logic signed [W+1:0] ds_w;
  logic [W+1:0] adq, adr, ads;
  logic [W+2:0] dsum;
  always_comb begin
    dq_w = (W+1)'(in_i.end_q) - (W+1)'(in_i.start_q);
    dr_w = (W+1)'(in_i.end_r) - (W+1)'(in_i.start_r);
    ds_w = (W+2)'(dq_w) + (W+2)'(dr_w);
    adq  = dq_w[W] ? (W+2)'(-(W+2)'(dq_w)) : (W+2)'(dq_w);
    adr  = dr_w[W] ? (W+2)'(-(W+2)'(dr_w)) : (W+2)'(dr_w);
    ads  = ds_w[W+1] ? (W+2)'(-ds_w) : (W+2)'(ds_w);
    dsum = (W+3)'(adq) + (W+3)'(adr) + (W+3)'(ads);
  end

  // stage valid and last bits
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q;
  logic s1_last_q, s2_last_q, s3_last_q, s4_last_q, s5_last_q, s6_last_q;
  num_t xn1_q, zn1_q;
  logic [DW-1:0] d1_q, d2_q, d3_q, d4_q, d5_q;
  logic issue;
  assign issue = busy_q && !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else if (in_i.valid && in_i.ready) begin
      busy_q <= 1'b1;
      i_q    <= '0;
    end else if (issue) begin
      busy_q <= busy_d;
      i_q    <= i_q + 1'b1;
    end
  end
  assign busy_d = (i_q != d_q);

  // capture the line on its input transfer
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      q0_q <= (W+1)'(in_i.start_q);
      r0_q <= (W+1)'(in_i.start_r);
      dq_q <= dq_w;
      dr_q <= dr_w;
      d_q  <= DW'(dsum >> 1);
    end
  end

  // advance all valid bits together; hold them on a stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else if (!stall) begin
      s1_v_q <= busy_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
    end
  end

  // stage 1: numerators; d=0 handled as d=1 with i=0 (gives the start cell)
  logic [DW-1:0] deff;
  assign deff = (d_q == '0) ? DW'(1) : d_q;
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      xn1_q     <= NW'(q0_q) * $signed({1'b0, deff}) + NW'(dq_q) * $signed({1'b0, i_q});
      zn1_q     <= NW'(r0_q) * $signed({1'b0, deff}) + NW'(dr_q) * $signed({1'b0, i_q});
      d1_q      <= deff;
      s1_last_q <= !busy_d;
    end
  end

  // stage 2: y numerator, sign and 2|n|+d for each cube component (x, y, z)
  num_t n2_w [3];
  mag_t m2_w [3];
  div_t dv2_w [3];
  always_comb begin
    n2_w[0] = xn1_q;
    n2_w[1] = -xn1_q - zn1_q;
    n2_w[2] = zn1_q;
    for (int c = 0; c < 3; c++) begin
      m2_w[c]    = n2_w[c][NW-1] ? mag_t'(-n2_w[c]) : mag_t'(n2_w[c]);
      dv2_w[c].a = mag_t'({m2_w[c], 1'b0}) + mag_t'(d1_q);
      dv2_w[c].k = '0;
    end
  end

  div_t dv2_q [3];
  div_t dv3_q [3];
  div_t dv4_q [3];
  div_t dv5_q [3];
  logic [2:0] neg2_q, neg3_q, neg4_q, neg5_q;

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      for (int c = 0; c < 3; c++) dv2_q[c] <= dv2_w[c];
      neg2_q    <= {n2_w[2][NW-1], n2_w[1][NW-1], n2_w[0][NW-1]};
      d2_q      <= d1_q;
      s2_last_q <= s1_last_q;
    end
  end

  // restoring division of a by 2d for quotient bits hi down to lo
  function automatic div_t div_bits(input div_t s, input logic [DW-1:0] d,
                                    input int hi, input int lo);
    div_t r;
    mag_t t;
    r = s;
    for (int b = int'(QB) - 1; b >= 0; b--) begin
      t = mag_t'({d, 1'b0}) << b;
      if (b <= hi && b >= lo && r.a >= t) begin
        r.a    = r.a - t;
        r.k[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // stages 3 to 5: quotient bits, high to low
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      for (int c = 0; c < 3; c++) begin
        dv3_q[c] <= div_bits(dv2_q[c], d2_q, int'(QB) - 1, B1_LO);
        dv4_q[c] <= div_bits(dv3_q[c], d3_q, B1_LO - 1, B2_LO);
        dv5_q[c] <= div_bits(dv4_q[c], d4_q, B2_LO - 1, 0);
      end
      neg3_q    <= neg2_q;
      neg4_q    <= neg3_q;
      neg5_q    <= neg4_q;
      d3_q      <= d2_q;
      d4_q      <= d3_q;
      d5_q      <= d4_q;
      s3_last_q <= s2_last_q;
      s4_last_q <= s3_last_q;
      s5_last_q <= s4_last_q;
    end
  end

  // stage 6: twice the rounding error is |d - remainder|; the worst one gives way
  logic signed [DW+1:0] t6_w [3];
  logic [DW:0]          e6_w [3];
  logic signed [QW-1:0] r6_w [3];
  logic signed [QW-1:0] fx, fz;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t6_w[c] = $signed({2'b00, d5_q}) - $signed({1'b0, dv5_q[c].a[DW:0]});
      e6_w[c] = t6_w[c][DW+1] ? (DW+1)'(-t6_w[c]) : (DW+1)'(t6_w[c]);
      r6_w[c] = neg5_q[c] ? -$signed(QW'(dv5_q[c].k)) : $signed(QW'(dv5_q[c].k));
    end
    fx = r6_w[0];
    fz = r6_w[2];
    if (e6_w[0] > e6_w[1] && e6_w[0] > e6_w[2]) fx = -r6_w[1] - r6_w[2];
    else if (e6_w[1] > e6_w[2]) fx = r6_w[0];
    else fz = -r6_w[0] - r6_w[1];
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      out_o.cell_q <= W'(fx);
      out_o.cell_r <= W'(fz);
      s6_last_q    <= s5_last_q;
    end
  end
  assign out_o.valid   = s6_v_q;
  assign out_o.is_last = s6_last_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> out_o.valid && $stable(out_o.cell_q) && $stable(out_o.cell_r)
              && $stable(out_o.is_last))
    else $error("output changed under stall");
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_i.ready) else $error("accept while busy");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !busy_d) |=> !busy_q) else $error("line did not end");
endmodule

FILE: tb/hlcw_tb_if.sv
`timescale 1ns / 100ps
// File for the hex line walker testbench; it defines no interfaces of its own.
// The testbench uses the channel interfaces of hdl/hlcw_if.sv, as the block does.

FILE: tb/hex_line_cell_walker_tb.sv
`timescale 1ns / 100ps
// Testbench for hex_line_cell_walker: drives start/end cell pairs and checks each
// streamed cell against an exact-rational line predictor. Depends on hlcw_pkg, hlcw_if and the DUT.
module hex_line_cell_walker_tb;

  localparam int W = int'(hlcw_pkg::MaxCoordBits);
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic signed [W-1:0] q;
    logic signed [W-1:0] r;
    logic                last;
  } cell_t;

  typedef struct {
    logic signed [W-1:0] sq, sr, eq, er;
    bit                  typed;   // expected cell typed in below
    logic signed [W-1:0] tq, tr;  // first cell when typed
  } line_row_t;

  logic clk_i, rst_ni;
  hlcw_in_if  #(W) in_ch();
  hlcw_out_if #(W) out_ch();

  hex_line_cell_walker #(.COORD_BITS(W)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  cell_t line_cells_q[$];
  int    n_fail = 0;
  int    cycle_cnt = 0;
  bit    calm = 0;      // no idling in the last part of the run

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Round num/den to nearest, ties away from zero (den > 0).
  function automatic int round_div(int num, int den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((-2 * num + den) / (2 * den));
  endfunction

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  // Queue the cells of the line from (sq,sr) to (eq,er).
  task automatic predict_line(logic signed [W-1:0] sq, sr, eq, er);
    int q0, r0, dq, dr, d, xn, zn, yn, rx, ry, rz, ex, ey, ez;
    cell_t c;
    q0 = int'(sq); r0 = int'(sr);
    dq = int'(eq) - q0;
    dr = int'(er) - r0;
    d = (iabs(dq) + iabs(dq + dr) + iabs(dr)) / 2;
    if (d == 0) begin
      c.q = sq; c.r = sr; c.last = 1'b1;
      line_cells_q.push_back(c);
      return;
    end
    for (int i = 0; i <= d; i++) begin
      xn = q0 * d + dq * i;
      zn = r0 * d + dr * i;
      yn = -xn - zn;
      rx = round_div(xn, d);
      ry = round_div(yn, d);
      rz = round_div(zn, d);
      ex = iabs(rx * d - xn);
      ey = iabs(ry * d - yn);
      ez = iabs(rz * d - zn);
      // The worst-rounded component gives way; ties fall to z, then y.
      if (ex > ey && ex > ez) rx = -ry - rz;
      else if (ey > ez) ry = -rx - rz;
      else rz = -rx - ry;
      c.q = rx[W-1:0]; c.r = rz[W-1:0]; c.last = (i == d);
      line_cells_q.push_back(c);
    end
  endtask

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("[hex_line_cell_walker] ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, then check each transfer.
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (line_cells_q.size() == 0) begin
          $error("unexpected cell q=%0d r=%0d", out_ch.cell_q, out_ch.cell_r);
          n_fail++;
        end else begin
          cell_t e;
          e = line_cells_q.pop_front();
          if (out_ch.cell_q !== e.q) begin
            $error("cell_q expected %0d actual %0d", e.q, out_ch.cell_q); n_fail++;
          end
          if (out_ch.cell_r !== e.r) begin
            $error("cell_r expected %0d actual %0d", e.r, out_ch.cell_r); n_fail++;
          end
          if (out_ch.is_last !== e.last) begin
            $error("is_last expected %0d actual %0d", e.last, out_ch.is_last); n_fail++;
          end
        end
      end
      // Hold ready low for a burst, or drop it now and then.
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Present one line and wait for its transfer, with an occasional random gap first.
  // Valid stays high on return; the caller drops it before idling.
  task automatic send_line(logic signed [W-1:0] sq, sr, eq, er, output cell_t first);
    int base;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.start_q <= sq; in_ch.start_r <= sr;
    in_ch.end_q   <= eq; in_ch.end_r   <= er;
    base = line_cells_q.size();
    predict_line(sq, sr, eq, er);
    first = line_cells_q[base];
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  line_row_t rows[$];

  function automatic line_row_t mk(int sq, sr, eq, er, bit typed = 0, int tq = 0, tr = 0);
    line_row_t x;
    x.sq = W'(sq); x.sr = W'(sr); x.eq = W'(eq); x.er = W'(er);
    x.typed = typed; x.tq = W'(tq); x.tr = W'(tr);
    return x;
  endfunction

  initial begin
    cell_t head;
    int sq, sr, eq, er, k, n;
    in_ch.valid <= 1'b0;
    in_ch.start_q <= '0; in_ch.start_r <= '0; in_ch.end_q <= '0; in_ch.end_r <= '0;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: zero distance, corner lines, axis lines, ties.
    rows.push_back(mk(0, 0, 0, 0, 1, 0, 0));
    rows.push_back(mk(-16, -16, -16, -16, 1, -16, -16));
    rows.push_back(mk(15, 15, 15, 15, 1, 15, 15));
    rows.push_back(mk(-16, 15, 15, -16, 1, -16, 15));   // corner to corner, d = 31
    rows.push_back(mk(15, -16, -16, 15, 1, 15, -16));
    rows.push_back(mk(-16, -16, 15, 15, 1, -16, -16));  // d = 62, the longest line
    rows.push_back(mk(15, 15, -16, -16, 1, 15, 15));
    rows.push_back(mk(-16, 0, 15, 0));
    rows.push_back(mk(0, -16, 0, 15));
    rows.push_back(mk(0, 0, 1, 0));
    rows.push_back(mk(0, 0, 2, -1));                    // rounding ties between axes
    rows.push_back(mk(0, 0, 1, 1));
    rows.push_back(mk(0, 0, -3, 2));
    rows.push_back(mk(3, -5, -4, 6));
    rows.push_back(mk(-7, 2, 5, -9));
    rows.push_back(mk(1, -2, 3, -6));
    rows.push_back(mk(-1, -1, 1, 1));
    rows.push_back(mk(10, 5, -10, -5));
    foreach (rows[j]) begin
      send_line(rows[j].sq, rows[j].sr, rows[j].eq, rows[j].er, head);
      // Typed-in first cell must agree with the predictor's.
      if (rows[j].typed) begin
        if (head.q !== rows[j].tq) begin
          $error("cell_q expected %0d actual %0d", rows[j].tq, head.q); n_fail++;
        end
        if (head.r !== rows[j].tr) begin
          $error("cell_r expected %0d actual %0d", rows[j].tr, head.r); n_fail++;
        end
      end
    end
    in_ch.valid <= 1'b0;

    // Pause until every cell has drained, then go on.
    while (line_cells_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    // Random lines: mostly short, a few long, some zero distance.
    for (k = 0; k < 202; k++) begin
      if (k == 175) calm = 1;
      n = $urandom_range(0, 9);
      sq = $urandom_range(0, 31) - 16;
      sr = $urandom_range(0, 31) - 16;
      if (n == 0) begin
        eq = sq; er = sr;
      end else if (n < 7) begin
        eq = sq + $urandom_range(0, 8) - 4;
        er = sr + $urandom_range(0, 8) - 4;
        if (eq > 15) eq = 15; if (eq < -16) eq = -16;
        if (er > 15) er = 15; if (er < -16) er = -16;
      end else begin
        eq = $urandom_range(0, 31) - 16;
        er = $urandom_range(0, 31) - 16;
      end
      if (k == 100) begin
        in_ch.valid <= 1'b0;
        while (line_cells_q.size() != 0) @(posedge clk_i);
        repeat (10) @(posedge clk_i);
      end
      send_line(W'(sq), W'(sr), W'(eq), W'(er), head);
    end
    in_ch.valid <= 1'b0;

    while (line_cells_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_fail == 0 && line_cells_q.size() == 0) begin
      $display("[hex_line_cell_walker] OK");
    end else begin
      $display("[hex_line_cell_walker] ERROR");
    end
    $finish;
  end
endmodule
